/* sv/rate_limited_event_queue_top_assert.svh */
// Assertion macros used by the rate limited event queue ring RTL.
// Both macros expect clk and rst_n in scope.
`ifndef RATE_LIMITED_EVENT_QUEUE_TOP_ASSERT_SVH
`define RATE_LIMITED_EVENT_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define RLEQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rleq assertion failed");

// Next-cycle implication, disabled while in reset.
`define RLEQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rleq assertion failed");

`endif

/* sv/rleq_pkg.sv */
// ----------------------------------------------------------------------------
// rleq_pkg
// Shared constants, codes and inter-module structs for the rate limited
// event queue.
// ----------------------------------------------------------------------------
package rleq_pkg;

  localparam int NUM_SOURCES = 16;
  localparam int RING_DEPTH  = 32;
  localparam int TIME_BITS   = 32;

  localparam int KIND_W      = 2;
  localparam int SRC_W       = 4;
  localparam int GAP_W       = 16;
  localparam int STATUS_W    = 3;
  localparam int FILL_OUT_W  = 5;

  localparam int SRC_IDX_W   = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int PTR_W       = $clog2(RING_DEPTH);

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK    = 2'd0,
    KIND_TRIGGER = 2'd1,
    KIND_POP     = 2'd2,
    KIND_LOAD    = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 3'd0,
    ST_QUEUED    = 3'd1,
    ST_THROTTLED = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_POPPED    = 3'd4,
    ST_EMPTY     = 3'd5
  } status_t;

  // command to the per-source timing table
  typedef struct packed {
    logic             en;
    kind_t            kind;
    logic [SRC_W-1:0] src;
    logic [GAP_W-1:0] gap;
  } table_cmd_t;

  // request to the id ring
  typedef struct packed {
    logic             en;
    logic             push;
    logic             pop;
    logic [SRC_W-1:0] id;
  } ring_req_t;

  // ring status, fill_nxt is the level after the current request
  typedef struct packed {
    logic             full;
    logic             empty;
    logic [PTR_W-1:0] fill_nxt;
  } ring_stat_t;

endpackage

/* sv/rleq_table.sv */
// ----------------------------------------------------------------------------
// rleq_table
// Millisecond counter and per-source interval / last-accept table. Decides
// whether a trigger passes and updates the source timestamp when it does.
// ----------------------------------------------------------------------------
module rleq_table (
  input  logic                clk,
  input  logic                rst_n,
  input  rleq_pkg::table_cmd_t cmd,
  output logic                pass
);
  import rleq_pkg::*;

  logic [TIME_BITS-1:0] now_r;
  logic [TIME_BITS-1:0] last_r [NUM_SOURCES];
  logic [GAP_W-1:0]     gap_r  [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] ever_r;

  logic [SRC_IDX_W-1:0] idx;
  logic [31:0]          src_ext;
  logic                 src_ok;
  logic [TIME_BITS-1:0] elapsed;

  always_comb begin
    src_ext = 32'(cmd.src);
    src_ok  = (src_ext < 32'(NUM_SOURCES));
    idx     = SRC_IDX_W'(cmd.src);
    // wrapped difference, modulo 2^TIME_BITS
    elapsed = now_r - last_r[idx];
    pass    = src_ok && (!ever_r[idx] || (elapsed > TIME_BITS'(gap_r[idx])));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r  <= '0;
      ever_r <= '0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
        last_r[i] <= '0;
        gap_r[i]  <= '0;
      end
    end else if (cmd.en) begin
      case (cmd.kind)
        KIND_TICK: begin
          now_r <= now_r + 1'b1;
        end
        KIND_TRIGGER: begin
          // timestamp moves even if the ring later drops the id
          if (pass) begin
            last_r[idx] <= now_r;
            ever_r[idx] <= 1'b1;
          end
        end
        KIND_LOAD: begin
          if (src_ok) begin
            gap_r[idx] <= cmd.gap;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* sv/rleq_ring.sv */
// ----------------------------------------------------------------------------
// rleq_ring
// Source id ring holding up to RING_DEPTH - 1 entries. Head points at the
// last removed slot, tail at the last written one. Pop data is registered.
// ----------------------------------------------------------------------------
`include "rate_limited_event_queue_top_assert.svh"

module rleq_ring (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rleq_pkg::ring_req_t         req,
  output rleq_pkg::ring_stat_t        stat,
  output logic [rleq_pkg::SRC_W-1:0]  rd_id
);
  import rleq_pkg::*;

  logic [PTR_W-1:0] head_r, head_nxt, head_inc;
  logic [PTR_W-1:0] tail_r, tail_nxt, tail_inc;
  logic [SRC_W-1:0] mem [RING_DEPTH];
  logic [SRC_W-1:0] rd_r;
  logic             push_ok, pop_ok;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] fill_of(input logic [PTR_W-1:0] h,
                                               input logic [PTR_W-1:0] t);
    return (t >= h) ? (t - h) : (t + PTR_W'(RING_DEPTH) - h);
  endfunction

  always_comb begin
    head_inc      = ptr_next(head_r);
    tail_inc      = ptr_next(tail_r);
    stat.full     = (tail_inc == head_r);
    stat.empty    = (head_r == tail_r);
    push_ok       = req.en && req.push && !stat.full;
    pop_ok        = req.en && req.pop && !stat.empty;
    tail_nxt      = push_ok ? tail_inc : tail_r;
    head_nxt      = pop_ok ? head_inc : head_r;
    stat.fill_nxt = fill_of(head_nxt, tail_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[tail_inc] <= req.id;
    end
    if (pop_ok) begin
      rd_r <= mem[head_inc];
    end
  end

  assign rd_id = rd_r;

  `RLEQ_ASSERT_IMPL(a_full_not_empty, stat.full, !stat.empty)
  `RLEQ_ASSERT_NEXT(a_drop_keeps_tail, req.en && req.push && stat.full, $stable(tail_r))
  `RLEQ_ASSERT_NEXT(a_pop_moves_head, pop_ok, head_r != $past(head_r))
  `RLEQ_ASSERT_NEXT(a_idle_holds_ptrs, !req.en, $stable(head_r) && $stable(tail_r))

endmodule

/* sv/rate_limited_event_queue_top.sv */
// Rate limited event queue: takes one transaction per clock while the result
// side keeps up and returns one result per transaction. Each item passes
// through the input register, then the result register, which drives
// out_tvalid. The table lookup, the time compare and the ring pointer update
// for an item all happen in the same cycle between those registers, so
// throughput is one item per cycle whenever the result side keeps up. No
// clearing pass runs after reset. Input kind travels in in_tuser, result
// status in out_tuser.
// ----------------------------------------------------------------------------
// rate_limited_event_queue_top
// Per-source throttled event FIFO: tick, trigger, pop and interval load.
// ----------------------------------------------------------------------------
module rate_limited_event_queue_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [3:0] source_id, [19:4] interval_ms, [23:20] zero
  input  logic [rleq_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [1:0] kind
  input  logic [rleq_pkg::KIND_W-1:0]          in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [3:0] popped_id, [8:4] fill_level, [15:9] zero
  output logic [rleq_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // [2:0] status
  output logic [rleq_pkg::STATUS_W-1:0]        out_tuser
);
  import rleq_pkg::*;

  logic              in_vld_r;
  kind_t             in_kind_r;
  logic [SRC_W-1:0]  in_src_r;
  logic [GAP_W-1:0]  in_gap_r;

  logic                  out_vld_r;
  status_t               out_status_r;
  logic [FILL_OUT_W-1:0] out_fill_r;

  logic       advance, fire, pass;
  status_t    status_nxt;
  table_cmd_t tcmd;
  ring_req_t  rreq;
  ring_stat_t rstat;
  logic [SRC_W-1:0] rd_id, popped;

  assign advance   = !out_vld_r || out_tready;
  assign fire      = in_vld_r && advance;
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_kind_r <= kind_t'(in_tuser);
      in_src_r  <= in_tdata[SRC_W-1:0];
      in_gap_r  <= in_tdata[SRC_W+GAP_W-1:SRC_W];
    end
  end

  always_comb begin
    tcmd.en   = fire;
    tcmd.kind = in_kind_r;
    tcmd.src  = in_src_r;
    tcmd.gap  = in_gap_r;

    rreq.en   = fire;
    rreq.push = (in_kind_r == KIND_TRIGGER) && pass;
    rreq.pop  = (in_kind_r == KIND_POP);
    rreq.id   = in_src_r;
  end

  rleq_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (tcmd),
    .pass  (pass)
  );

  rleq_ring u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rreq),
    .stat  (rstat),
    .rd_id (rd_id)
  );

  always_comb begin
    case (in_kind_r)
      KIND_TRIGGER: begin
        if (!pass) begin
          status_nxt = ST_THROTTLED;
        end else if (rstat.full) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          status_nxt = ST_QUEUED;
        end
      end
      KIND_POP: begin
        status_nxt = rstat.empty ? ST_EMPTY : ST_POPPED;
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status_r <= status_nxt;
      out_fill_r   <= FILL_OUT_W'(rstat.fill_nxt);
    end
  end

  // ring read register only loads on a pop, so gate it by status
  assign popped     = (out_status_r == ST_POPPED) ? rd_id : '0;
  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(OUT_TDATA_W - SRC_W - FILL_OUT_W){1'b0}}, out_fill_r, popped};

endmodule
